[hw/rtl/mdpb_pkg.sv]
`default_nettype none

package mdpb_pkg;

   // Bank geometry
   localparam int BANK_DEPTH = 256;
   localparam int ADDR_W     = $clog2(BANK_DEPTH);
   localparam int COUNT_W    = $clog2(BANK_DEPTH + 1);

   // Field widths of the channels
   localparam int JOINT_W  = 16;
   localparam int DIST_W   = 36;
   localparam int PCOUNT_W = 9;

   // Angle precision: low ANGLE_BITS of each joint field, sign-extended (at most JOINT_W)
   localparam int ANGLE_BITS = 16;
   localparam int DIFF_W     = ANGLE_BITS + 1;
   localparam int SQ_W       = 2 * ANGLE_BITS + 1;
   localparam int SUM_W      = SQ_W + 2;
   localparam int WIDE_W     = (SUM_W > DIST_W) ? SUM_W : DIST_W;

   localparam logic [DIST_W-1:0] DIST_MAX     = {DIST_W{1'b1}};
   localparam logic [DIST_W-1:0] THRESH_RESET = DIST_W'(1677722);

   // Command codes
   localparam logic CMD_OFFER   = 1'b0;
   localparam logic CMD_PRELOAD = 1'b1;

   typedef logic signed [ANGLE_BITS-1:0] angle_type;

   typedef struct packed {
      angle_type a;
      angle_type b;
      angle_type c;
      angle_type d;
   } point_type;

   typedef struct packed {
      logic                      cmd;
      logic signed [JOINT_W-1:0] joint_a;
      logic signed [JOINT_W-1:0] joint_b;
      logic signed [JOINT_W-1:0] joint_c;
      logic signed [JOINT_W-1:0] joint_d;
   } req_type;

   typedef struct packed {
      logic                stored;
      logic                bank_full;
      logic [DIST_W-1:0]   nearest_sq_distance;
      logic [PCOUNT_W-1:0] point_count;
   } rsp_type;

   // Distance unit status toward the sequencer
   typedef struct packed {
      logic              valid;
      logic              busy;
      logic [DIST_W-1:0] sum;
   } dist_out_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE
   } state_type;

endpackage

`default_nettype wire

[hw/rtl/mdpb_dist.sv]
`default_nettype none

// Two-stage squared-distance unit: one stored point per cycle.
module mdpb_dist (
   input  wire                     clock,
   input  wire                     reset,
   input  mdpb_pkg::point_type     probe,
   input  mdpb_pkg::point_type     entry,
   input  wire                     entry_valid,
   output mdpb_pkg::dist_out_type  result
);
   import mdpb_pkg::*;

   angle_type               probe_j [4];
   angle_type               entry_j [4];
   logic signed [DIFF_W-1:0] diff   [4];
   logic [SQ_W-1:0]          sq_in  [4];
   logic [SQ_W-1:0]          sq_ff  [4];
   logic                     s1_v_ff;
   logic                     s1_v_in;
   logic [WIDE_W-1:0]        sum_wide;
   logic [DIST_W-1:0]        sum_in;
   logic [DIST_W-1:0]        sum_ff;
   logic                     s2_v_ff;
   logic                     s2_v_in;

   assign probe_j[0] = probe.a;
   assign probe_j[1] = probe.b;
   assign probe_j[2] = probe.c;
   assign probe_j[3] = probe.d;
   assign entry_j[0] = entry.a;
   assign entry_j[1] = entry.b;
   assign entry_j[2] = entry.c;
   assign entry_j[3] = entry.d;

   // Stage 1: per-joint difference and square
   always_comb begin
      logic signed [2*DIFF_W-1:0] prod;
      for (int k = 0; k < 4; k++) begin
         diff[k]  = DIFF_W'(probe_j[k]) - DIFF_W'(entry_j[k]);
         prod     = diff[k] * diff[k];
         sq_in[k] = prod[SQ_W-1:0];
      end
   end

   assign s1_v_in = entry_valid;

   // Stage 2: sum of squares, saturated to the distance width
   always_comb begin
      sum_wide = WIDE_W'(sq_ff[0]) + WIDE_W'(sq_ff[1])
               + WIDE_W'(sq_ff[2]) + WIDE_W'(sq_ff[3]);
      if (sum_wide > WIDE_W'(DIST_MAX)) begin
         sum_in = DIST_MAX;
      end else begin
         sum_in = sum_wide[DIST_W-1:0];
      end
   end

   assign s2_v_in = s1_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         sq_ff[k] <= sq_in[k];
      end
      sum_ff <= sum_in;
   end

   assign result.valid = s2_v_ff;
   assign result.busy  = s1_v_ff | s2_v_ff;
   assign result.sum   = sum_ff;

endmodule

`default_nettype wire

[hw/rtl/min_distance_point_bank.sv]
`default_nettype none

// Minimum-distance point bank.
// Request channel (req_valid/req_ready, req_data): one four-joint position
// per beat, cmd selects offer (distance check) or preload (append unless full).
// Response channel (rsp_valid/rsp_ready, rsp_data): one beat per request with
// the stored and bank_full flags, the nearest squared distance seen before
// the append (all ones on an empty bank) and the point count afterwards.
// csr_we/csr_wdata write the 36-bit squared-distance threshold; write it
// only while the block is idle.
// Each request scans the stored points one per cycle through a single
// distance unit reading one memory port; on an empty bank there is no
// scan. The block returns to idle after each response is committed, before
// the next acceptance. The block takes one request at a time.
// The response sits in an output register: the next request is accepted
// while it waits, and the block holds its own result only if the receiver
// still stalls when that next scan is done.
// Reset empties the bank (count to zero) and loads the threshold reset
// value; there is no clearing pass, since only written entries are read.
module min_distance_point_bank (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  mdpb_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output mdpb_pkg::rsp_type                  rsp_data,
   input  wire                                csr_we,
   input  wire  [mdpb_pkg::DIST_W-1:0]        csr_wdata
);
   import mdpb_pkg::*;

   state_type           state_ff;
   state_type           state_in;
   logic [COUNT_W-1:0]  count_ff;
   logic [COUNT_W-1:0]  count_in;
   logic [ADDR_W-1:0]   idx_ff;
   logic [ADDR_W-1:0]   idx_in;
   logic [DIST_W-1:0]   thr_ff;
   logic [DIST_W-1:0]   nearest_ff;
   logic [DIST_W-1:0]   nearest_in;
   point_type           pt_ff;
   point_type           pt_in;
   logic                cmd_ff;
   logic                cmd_in;
   logic                rd_v_ff;
   point_type           rd_data_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   rsp_type             rsp_data_ff;
   rsp_type             rsp_data_in;
   dist_out_type        dist_res;

   point_type           mem [BANK_DEPTH];

   logic                accept;
   logic                scan_en;
   logic                last_issue;
   logic                pipe_empty;
   logic                slot_free;
   logic                commit;
   logic                full;
   logic                do_store;

   assign accept     = req_valid & req_ready;
   assign last_issue = (COUNT_W'(idx_ff) == (count_ff - COUNT_W'(1)));
   assign pipe_empty = ~rd_v_ff & ~dist_res.busy;
   assign slot_free  = ~rsp_valid_ff | rsp_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (count_ff == '0) ? ST_DRAIN : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (pipe_empty) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      scan_en   = 1'b0;
      commit    = 1'b0;
      case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_SCAN:   scan_en   = 1'b1;
         ST_DRAIN:  ;
         ST_DECIDE: commit    = slot_free;
         default:   ;
      endcase
   end

   // Append decision
   assign full     = (count_ff >= COUNT_W'(BANK_DEPTH));
   assign do_store = ~full & ((count_ff == '0) || (cmd_ff == CMD_PRELOAD)
                              || (nearest_ff > thr_ff));

   // Datapath next values
   always_comb begin
      pt_in.a = req_data.joint_a[ANGLE_BITS-1:0];
      pt_in.b = req_data.joint_b[ANGLE_BITS-1:0];
      pt_in.c = req_data.joint_c[ANGLE_BITS-1:0];
      pt_in.d = req_data.joint_d[ANGLE_BITS-1:0];
      cmd_in  = req_data.cmd;

      idx_in = idx_ff;
      if (accept) begin
         idx_in = '0;
      end else if (scan_en) begin
         idx_in = idx_ff + ADDR_W'(1);
      end

      nearest_in = nearest_ff;
      if (accept) begin
         nearest_in = DIST_MAX;
      end else if (dist_res.valid && (dist_res.sum < nearest_ff)) begin
         nearest_in = dist_res.sum;
      end

      count_in = count_ff;
      if (commit && do_store) begin
         count_in = count_ff + COUNT_W'(1);
      end

      rsp_data_in.stored              = do_store;
      rsp_data_in.bank_full           = full;
      rsp_data_in.nearest_sq_distance = nearest_ff;
      rsp_data_in.point_count         = PCOUNT_W'(count_in);

      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         thr_ff       <= THRESH_RESET;
         rd_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_v_ff      <= scan_en;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            thr_ff <= csr_wdata;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      nearest_ff <= nearest_in;
      if (accept) begin
         pt_ff  <= pt_in;
         cmd_ff <= cmd_in;
      end
      if (commit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Point memory: append port and registered scan read port
   always_ff @(posedge clock) begin
      if (commit && do_store) begin
         mem[count_ff[ADDR_W-1:0]] <= pt_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[idx_ff];
   end

   mdpb_dist u_dist (
      .clock       (clock),
      .reset       (reset),
      .probe       (pt_ff),
      .entry       (rd_data_ff),
      .entry_valid (rd_v_ff),
      .result      (dist_res)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(BANK_DEPTH))
      else $error("point count beyond bank depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff)))
         |-> (count_ff == ($past(count_ff) + COUNT_W'(1))))
      else $error("point count moved by other than one");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.stored && rsp_data_ff.bank_full))
      else $error("stored and bank_full both set");

   a_nearest_falls: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DRAIN) && ($past(state_ff) == ST_DRAIN))
         |-> (nearest_ff <= $past(nearest_ff)))
      else $error("nearest distance rose during scan");

endmodule

`default_nettype wire
